// ===== rtl/core/hsv_pkg.sv =====
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the block.
package hsv_pkg;

  // Fixed point format of every color field.
  localparam int FRAC_BITS = 16;
  localparam int FW        = FRAC_BITS + 1;
  localparam int PW        = 2 * FW;
  localparam int SW        = 3;
  localparam int QDEPTH    = 4;
  localparam int QPW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  // Hue sectors; the last one (magenta to red) is the default arm.
  localparam logic [SW-1:0] SEC_RED_YEL = 3'd0;
  localparam logic [SW-1:0] SEC_YEL_GRN = 3'd1;
  localparam logic [SW-1:0] SEC_GRN_CYN = 3'd2;
  localparam logic [SW-1:0] SEC_CYN_BLU = 3'd3;
  localparam logic [SW-1:0] SEC_BLU_MAG = 3'd4;

  // One classified word handed from the front to the back.
  typedef struct packed {
    logic                 grey;
    logic [SW-1:0]        sector;
    logic [FRAC_BITS-1:0] frac;
    logic [FW-1:0]        sat;
    logic [FW-1:0]        val;
  } hsv_item_t;

endpackage

// ===== rtl/core/hsv_front.sv =====
// Front end: clamps the inputs and splits the hue into sector and fraction.
// Depends on hsv_pkg.
module hsv_front (
  input  logic [hsv_pkg::FW-1:0] hue,
  input  logic [hsv_pkg::FW-1:0] saturation,
  input  logic [hsv_pkg::FW-1:0] brightness,
  output hsv_pkg::hsv_item_t     item
);
  import hsv_pkg::*;

  logic [FRAC_BITS-1:0] hue_w;
  logic [FRAC_BITS+2:0] hue6;

  // A hue of one or more wraps to zero; below one the top bit is clear.
  assign hue_w = (hue >= ONE) ? '0 : hue[FRAC_BITS-1:0];

  // Times six as a sum of two shifts.
  assign hue6 = ((FRAC_BITS+3)'(hue_w) << 2) + ((FRAC_BITS+3)'(hue_w) << 1);

  // Clamp saturation and value to one and pack the word.
  always_comb begin
    item.sat    = (saturation > ONE) ? ONE : saturation;
    item.val    = (brightness > ONE) ? ONE : brightness;
    item.grey   = (saturation == '0);
    item.sector = hue6[FRAC_BITS +: SW];
    item.frac   = hue6[FRAC_BITS-1:0];
  end

endmodule

// ===== rtl/core/hsv_queue.sv =====
// Short register queue between the front and back ends.
// Depends on hsv_pkg.
module hsv_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hsv_pkg::hsv_item_t push_item,
  output logic               full,
  output logic               q_valid,
  input  logic               q_ready,
  output hsv_pkg::hsv_item_t q_item
);
  import hsv_pkg::*;

  hsv_item_t      entries [QDEPTH];
  logic [QPW-1:0] wr_ptr;
  logic [QPW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           pop;

  assign full    = (count == QCW'(QDEPTH));
  assign q_valid = (count != '0);
  assign pop     = q_valid && q_ready;
  assign q_item  = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCW'(QDEPTH))
    else $error("queue fill count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");
`endif

endmodule

// ===== rtl/core/hsv_back.sv =====
// Back end: two multiply stages, sector routing and the output register.
// Depends on hsv_pkg.
module hsv_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  hsv_pkg::hsv_item_t     q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [hsv_pkg::FW-1:0] red,
  output logic [hsv_pkg::FW-1:0] green,
  output logic [hsv_pkg::FW-1:0] blue
);
  import hsv_pkg::*;

  // First stage registers.
  logic          a_valid;
  logic          a_grey;
  logic [SW-1:0] a_sector;
  logic [FW-1:0] a_val;
  logic [FW-1:0] a_m;
  logic [FW-1:0] a_sf;
  logic [FW-1:0] a_sg;

  logic          a_ready;
  logic          o_ready;
  logic [PW-1:0] prod_m;
  logic [PW-1:0] prod_sf;
  logic [PW-1:0] prod_sg;
  logic [PW-1:0] prod_n;
  logic [PW-1:0] prod_k;
  logic [FW-1:0] n_val;
  logic [FW-1:0] k_val;
  logic [FW-1:0] red_next;
  logic [FW-1:0] green_next;
  logic [FW-1:0] blue_next;

  assign o_ready = !out_valid || out_ready;
  assign a_ready = !a_valid || o_ready;
  assign q_ready = a_ready;

  // First products: v(1-s), s*f and s(1-f).
  assign prod_m  = PW'(q_item.val) * PW'(ONE - q_item.sat);
  assign prod_sf = PW'(q_item.sat) * PW'(q_item.frac);
  assign prod_sg = PW'(q_item.sat) * PW'(ONE - FW'(q_item.frac));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && q_valid) begin
      a_grey   <= q_item.grey;
      a_sector <= q_item.sector;
      a_val    <= q_item.val;
      a_m      <= prod_m[FRAC_BITS +: FW];
      a_sf     <= prod_sf[FRAC_BITS +: FW];
      a_sg     <= prod_sg[FRAC_BITS +: FW];
    end
  end

  // Second products: v(1-s*f) and v(1-s(1-f)).
  assign prod_n = PW'(a_val) * PW'(ONE - a_sf);
  assign prod_k = PW'(a_val) * PW'(ONE - a_sg);
  assign n_val  = prod_n[FRAC_BITS +: FW];
  assign k_val  = prod_k[FRAC_BITS +: FW];

  // Route the four values to the channels by sector.
  always_comb begin
    if (a_grey) begin
      red_next   = a_val;
      green_next = a_val;
      blue_next  = a_val;
    end else begin
      unique case (a_sector)
        SEC_RED_YEL: begin
          red_next = a_val; green_next = k_val; blue_next = a_m;
        end
        SEC_YEL_GRN: begin
          red_next = n_val; green_next = a_val; blue_next = a_m;
        end
        SEC_GRN_CYN: begin
          red_next = a_m; green_next = a_val; blue_next = k_val;
        end
        SEC_CYN_BLU: begin
          red_next = a_m; green_next = n_val; blue_next = a_val;
        end
        SEC_BLU_MAG: begin
          red_next = k_val; green_next = a_m; blue_next = a_val;
        end
        default: begin
          red_next = a_val; green_next = a_m; blue_next = n_val;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready && a_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

`ifndef SYNTHESIS
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
    else $error("output channel above one");
  a_grey_equal: assert property (@(posedge clk) disable iff (rst)
    a_valid && o_ready && a_grey |=> (red == green) && (green == blue))
    else $error("grey word gave unequal channels");
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    a_valid && !o_ready |=> a_valid && $stable(a_m) && $stable(a_val))
    else $error("first stage changed while stalled");
`endif

endmodule

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, Q1.16 fields, one word per clock while out_ready does not stall it.
// An accepted word is written into the queue at the accept edge, then passes through the
// first multiply stage and then the output register before it shows as output valid.
// Throughput is one word per cycle while out_ready is high: every back end stage then takes a new word each cycle.
// Reset clears the queue pointers, the queue fill count and the stage valid bits; no other state.
// Depends on hsv_pkg, hsv_front, hsv_queue and hsv_back.
module hsv_to_rgb_converter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [hsv_pkg::FW-1:0] hue,
  input  logic [hsv_pkg::FW-1:0] saturation,
  input  logic [hsv_pkg::FW-1:0] brightness,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [hsv_pkg::FW-1:0] red,
  output logic [hsv_pkg::FW-1:0] green,
  output logic [hsv_pkg::FW-1:0] blue
);
  import hsv_pkg::*;

  hsv_item_t front_item;
  hsv_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_ready;

  // Classify the incoming word.
  hsv_front u_front (
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .item       (front_item)
  );

  assign in_ready = !q_full;

  // Decouple front and back.
  hsv_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // Arithmetic and routing.
  hsv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

endmodule
